### rtl/core/window_repeat_bit_encoder_defines.svh
// ---------------------------------------------------------------------------
// window repeat bit encoder: assertion macros
// shared checking macros for the encoder modules
// ---------------------------------------------------------------------------
`ifndef WINDOW_REPEAT_BIT_ENCODER_DEFINES_SVH
`define WINDOW_REPEAT_BIT_ENCODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define WRBE_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define WRBE_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/wrbe_pkg.sv
// ---------------------------------------------------------------------------
// wrbe_pkg
// types, constants and helpers shared by the window repeat bit encoder
// ---------------------------------------------------------------------------
package wrbe_pkg;

  localparam int MAX_BLOCK   = 32;
  localparam int BLK_W       = 32;
  localparam int CNT_W       = 6;
  localparam int CODE_W      = 64;
  localparam int LEN_W       = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_TDATA_W = 8;

  localparam logic [CNT_W-1:0] BS_RESET     = 6'd8;
  localparam logic [CNT_W-1:0] BS_MAX       = 6'(MAX_BLOCK);
  localparam logic [CNT_W-1:0] BS_MIN       = 6'd1;

  typedef struct packed {
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              end_of_stream;
  } result_t;

  // one or two results caused by one request
  typedef struct packed {
    result_t res0;
    result_t res1;
    logic    two;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [BLK_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [BLK_W-1:0] m;
    if (n >= 6'(BLK_W)) begin
      m = '1;
    end else begin
      m = (BLK_W'(1) << n) - BLK_W'(1);
    end
    return m;
  endfunction

endpackage

### rtl/core/wrbe_front.sv
// ---------------------------------------------------------------------------
// wrbe_front
// accepts blocks, compares with the held block and builds result commands
// ---------------------------------------------------------------------------
`include "window_repeat_bit_encoder_defines.svh"

module wrbe_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr,
  input  logic [wrbe_pkg::CNT_W-1:0]      cfg_value,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wrbe_pkg::BLK_W-1:0]      win_bits,
  input  logic [wrbe_pkg::CNT_W-1:0]      bit_count,
  input  logic                            is_last,
  input  wrbe_pkg::qstat_t                qstat,
  output logic                            push,
  output wrbe_pkg::cmd_t                  push_cmd
);

  logic [wrbe_pkg::CNT_W-1:0] block_size_r;
  logic [wrbe_pkg::BLK_W-1:0] held_r, held_nxt;
  logic                       have_held_r, have_held_nxt;

  logic                       accept;
  logic [wrbe_pkg::CNT_W-1:0] bs, cnt;
  logic [wrbe_pkg::BLK_W-1:0] blk, held;
  logic [wrbe_pkg::CODE_W-1:0] blk64, held64;
  logic [wrbe_pkg::LEN_W-1:0] bs_len, bs_plain, part_len;
  logic                       full, last, eq;
  wrbe_pkg::cmd_t             cmd;
  logic                       has_res;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (block_size_r == '0) begin
      bs = wrbe_pkg::BS_MIN;
    end else if (block_size_r > wrbe_pkg::BS_MAX) begin
      bs = wrbe_pkg::BS_MAX;
    end else begin
      bs = block_size_r;
    end
    if (bit_count == '0) begin
      cnt = wrbe_pkg::BS_MIN;
    end else if (bit_count > bs) begin
      cnt = bs;
    end else begin
      cnt = bit_count;
    end
  end

  assign full     = (cnt == bs);
  assign last     = is_last || !full;
  assign blk      = win_bits & wrbe_pkg::low_mask(cnt);
  assign held     = held_r & wrbe_pkg::low_mask(bs);
  assign eq       = (held == blk);
  assign blk64    = {{(wrbe_pkg::CODE_W - wrbe_pkg::BLK_W){1'b0}}, blk};
  assign held64   = {{(wrbe_pkg::CODE_W - wrbe_pkg::BLK_W){1'b0}}, held};
  assign bs_plain = {1'b0, bs};
  assign bs_len   = bs_plain + 7'd1;
  assign part_len = bs_len + {1'b0, cnt};

  always_comb begin
    cmd           = '0;
    has_res       = 1'b0;
    held_nxt      = held_r;
    have_held_nxt = have_held_r;
    if (!have_held_r) begin
      if (last) begin
        // lone block goes out raw
        has_res                = 1'b1;
        cmd.res0.code_bits     = blk64;
        cmd.res0.code_length   = {1'b0, cnt};
        cmd.res0.end_of_stream = 1'b1;
        held_nxt               = '0;
        have_held_nxt          = 1'b0;
      end else begin
        held_nxt      = blk;
        have_held_nxt = 1'b1;
      end
    end else if (!full) begin
      // marker, held block, then the partial block
      has_res                = 1'b1;
      cmd.res0.code_bits     = 64'd1 | (held64 << 1) | (blk64 << bs_len);
      cmd.res0.code_length   = part_len;
      cmd.res0.end_of_stream = 1'b1;
      held_nxt               = '0;
      have_held_nxt          = 1'b0;
    end else begin
      has_res = 1'b1;
      if (eq) begin
        cmd.res0.code_bits   = '0;
        cmd.res0.code_length = 7'd1;
      end else begin
        cmd.res0.code_bits   = 64'd1 | (held64 << 1);
        cmd.res0.code_length = bs_len;
      end
      if (last) begin
        cmd.two                = 1'b1;
        cmd.res1.end_of_stream = 1'b1;
        if (eq) begin
          cmd.res1.code_bits   = 64'd1 | (blk64 << 1);
          cmd.res1.code_length = bs_len;
        end else begin
          cmd.res1.code_bits   = blk64;
          cmd.res1.code_length = bs_plain;
        end
        held_nxt      = '0;
        have_held_nxt = 1'b0;
      end else begin
        held_nxt = blk;
      end
    end
  end

  assign push     = accept && has_res;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= wrbe_pkg::BS_RESET;
      have_held_r  <= 1'b0;
      held_r       <= '0;
    end else begin
      if (cfg_wr) begin
        block_size_r <= cfg_value;
      end
      if (accept) begin
        have_held_r <= have_held_nxt;
        held_r      <= held_nxt;
      end
    end
  end

  `WRBE_ASSERT_NEXT(a_partial_ends_stream, clk, rst_n, accept && !full, !have_held_r,
    "partial block left a held block behind")
  `WRBE_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push, !qstat.full,
    "command pushed into a full queue")
  `WRBE_ASSERT_NOW(a_last_empties, clk, rst_n, accept && last && has_res,
    !have_held_nxt && (cmd.two ? cmd.res1.end_of_stream : cmd.res0.end_of_stream),
    "final request did not close the stream")

endmodule

### rtl/core/wrbe_queue.sv
// ---------------------------------------------------------------------------
// wrbe_queue
// short command queue between the front and the back
// ---------------------------------------------------------------------------
module wrbe_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wrbe_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output wrbe_pkg::cmd_t   head,
  output wrbe_pkg::qstat_t qstat
);

  wrbe_pkg::cmd_t              mem_r [wrbe_pkg::QUEUE_DEPTH];
  logic [wrbe_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [wrbe_pkg::QCNT_W-1:0] count_r;

  assign qstat.full  = (count_r == wrbe_pkg::QCNT_W'(wrbe_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign head        = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/core/wrbe_back.sv
// ---------------------------------------------------------------------------
// wrbe_back
// unpacks queued commands into single results behind an output register
// ---------------------------------------------------------------------------
`include "window_repeat_bit_encoder_defines.svh"

module wrbe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  wrbe_pkg::cmd_t    head,
  input  wrbe_pkg::qstat_t  qstat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output wrbe_pkg::result_t out_res
);

  logic              out_valid_r;
  wrbe_pkg::result_t out_res_r;
  logic              sel_r, sel_nxt;
  logic              load, take;

  assign load = !out_valid_r || out_ready;
  assign take = load && !qstat.empty;
  // second result of a two-result command pops it
  assign pop  = take && (!head.two || sel_r);

  always_comb begin
    sel_nxt = sel_r;
    if (take) begin
      sel_nxt = head.two && !sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (load) begin
        out_valid_r <= !qstat.empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r <= sel_r ? head.res1 : head.res0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `WRBE_ASSERT_NOW(a_sel_has_head, clk, rst_n, sel_r, !qstat.empty,
    "second result pending with an empty queue")
  `WRBE_ASSERT_NOW(a_sel_two, clk, rst_n, sel_r, head.two,
    "second result pending on a one-result command")
  `WRBE_ASSERT_NOW(a_pop_on_load, clk, rst_n, pop, load && !qstat.empty,
    "queue popped while the output register was held")

endmodule

### rtl/core/window_repeat_bit_encoder.sv
// ---------------------------------------------------------------------------
// window_repeat_bit_encoder
// repeat coding of a bit stream block by block
// ---------------------------------------------------------------------------
// blocks enter on the in_ stream, one request per block; in_tlast marks the
// final block of a stream (a short block ends the stream as well). coded
// results leave on the out_ stream, out_tlast on the final result of a stream.
// block_size is written through the cfg_ channel, which is always ready, and
// must only change while the encoder is idle.
// a request's results pass through the command queue and then the output
// register before they appear on out_. throughput: one block per cycle
// while the command queue is not full; a block that gives two results (a
// full final block after a held one) loads the output register once per
// result; the back end sends one result per cycle while out_tready is high.
// a four-entry command queue lets the front keep taking blocks while the
// output is stalled; in_tready drops only when that queue is full.
// reset clears the held block, the queue and the output valid flag and sets
// block_size to 8; no result is pending after reset.
// ---------------------------------------------------------------------------
module window_repeat_bit_encoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_tvalid,
  output logic                                cfg_tready,
  // block_size [5:0], zero pad [7:6]
  input  logic [wrbe_pkg::CFG_TDATA_W-1:0]    cfg_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // win_bits [31:0], bit_count [37:32], zero pad [39:38]
  input  logic [wrbe_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // code_bits [63:0], code_length [70:64], zero pad [71]
  output logic [wrbe_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast
);

  wrbe_pkg::qstat_t  qstat;
  wrbe_pkg::cmd_t    push_cmd, head;
  wrbe_pkg::result_t out_res;
  logic              push, pop;

  assign cfg_tready = 1'b1;

  wrbe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_tvalid && cfg_tready),
    .cfg_value  (cfg_tdata[wrbe_pkg::CNT_W-1:0]),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .win_bits   (in_tdata[wrbe_pkg::BLK_W-1:0]),
    .bit_count  (in_tdata[wrbe_pkg::BLK_W +: wrbe_pkg::CNT_W]),
    .is_last    (in_tlast),
    .qstat      (qstat),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  wrbe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  wrbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {1'b0, out_res.code_length, out_res.code_bits};
  assign out_tlast = out_res.end_of_stream;

endmodule
